[rtl/eur_pkg.sv]
// shared types, constants and register codes for the ultrasonic echo ranger
package eur_pkg;

  localparam int DEF_COUNT_BITS   = 16;
  localparam int DEF_HOLDOFF_BITS = 20;

  localparam int HOLDOFF_REG_BITS = 20;
  localparam int TIMEOUT_REG_BITS = 16;
  localparam int SPEED_REG_BITS   = 16;
  localparam int RANGE_BITS       = 23;
  localparam int WIDTH_OUT_BITS   = 16;
  localparam int CFG_DATA_BITS    = 23;
  localparam int CFG_INDEX_BITS   = 3;
  localparam int DIST_SHIFT       = 9;

  localparam int TRIG_LOW_TICKS  = 3;
  localparam int TRIG_HIGH_TICKS = 10;

  localparam logic [HOLDOFF_REG_BITS-1:0] HOLDOFF_RESET = 20'd60000;
  localparam logic [TIMEOUT_REG_BITS-1:0] TIMEOUT_RESET = 16'd30000;
  localparam logic [SPEED_REG_BITS-1:0]   SPEED_RESET   = 16'd2248;
  localparam logic [RANGE_BITS-1:0]       MIN_RESET     = 23'd512;
  localparam logic [RANGE_BITS-1:0]       MAX_RESET     = 23'd102400;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_HOLDOFF = 3'd0,
    CFG_TIMEOUT = 3'd1,
    CFG_SPEED   = 3'd2,
    CFG_MIN     = 3'd3,
    CFG_MAX     = 3'd4
  } eur_cfg_index_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_HOLD  = 3'd1,
    PH_TLOW  = 3'd2,
    PH_THIGH = 3'd3,
    PH_WAIT  = 3'd4,
    PH_MEAS  = 3'd5
  } eur_phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_EDGE = 2'd1,
    ST_STUCK   = 2'd2,
    ST_RANGE   = 2'd3
  } eur_status_e;

  typedef struct packed {
    logic start_request;
    logic echo_level;
  } eur_in_t;

  typedef struct packed {
    logic                      trigger_level;
    logic                      busy_res;
    logic                      done_res;
    logic [1:0]                status;
    logic [WIDTH_OUT_BITS-1:0] width_us;
    logic [RANGE_BITS-1:0]     distance_q8;
  } eur_out_t;

  typedef struct packed {
    logic [HOLDOFF_REG_BITS-1:0] holdoff_us;
    logic [TIMEOUT_REG_BITS-1:0] echo_timeout;
    logic [SPEED_REG_BITS-1:0]   speed_q16;
    logic [RANGE_BITS-1:0]       min_range_q8;
    logic [RANGE_BITS-1:0]       max_range_q8;
  } eur_cfg_t;

  // flags of one tick, passed from the sequencer to the range stage
  typedef struct packed {
    logic        trig;
    logic        busy;
    logic        done;
    logic        measured;
    eur_status_e status;
  } eur_flags_t;

endpackage

[rtl/eur_cfg_regs.sv]
// configuration register file of the echo ranger
module eur_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [eur_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [eur_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output eur_pkg::eur_cfg_t                    cfg
);
  import eur_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.holdoff_us   <= HOLDOFF_RESET;
      cfg.echo_timeout <= TIMEOUT_RESET;
      cfg.speed_q16    <= SPEED_RESET;
      cfg.min_range_q8 <= MIN_RESET;
      cfg.max_range_q8 <= MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HOLDOFF: cfg.holdoff_us   <= cfg_data[HOLDOFF_REG_BITS-1:0];
        CFG_TIMEOUT: cfg.echo_timeout <= cfg_data[TIMEOUT_REG_BITS-1:0];
        CFG_SPEED:   cfg.speed_q16    <= cfg_data[SPEED_REG_BITS-1:0];
        CFG_MIN:     cfg.min_range_q8 <= cfg_data[RANGE_BITS-1:0];
        CFG_MAX:     cfg.max_range_q8 <= cfg_data[RANGE_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/eur_step.sv]
// per-tick sequencer: holdoff, trigger pulse, echo rise wait and width count
module eur_step #(
  parameter int COUNT_BITS   = eur_pkg::DEF_COUNT_BITS,
  parameter int HOLDOFF_BITS = eur_pkg::DEF_HOLDOFF_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_fire,
  input  eur_pkg::eur_in_t        in_data,
  input  eur_pkg::eur_cfg_t       cfg,
  output eur_pkg::eur_flags_t     res_flags,
  output logic [COUNT_BITS-1:0]   res_width
);
  import eur_pkg::*;

  localparam int HCMP_BITS = (HOLDOFF_BITS > HOLDOFF_REG_BITS) ? HOLDOFF_BITS
                                                                : HOLDOFF_REG_BITS;
  localparam int TCMP_BITS = (COUNT_BITS > TIMEOUT_REG_BITS) ? COUNT_BITS
                                                              : TIMEOUT_REG_BITS;
  localparam logic [HOLDOFF_BITS-1:0] HOLD_MAX  = {HOLDOFF_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0]   COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0]   TLOW_END  = COUNT_BITS'(TRIG_LOW_TICKS);
  localparam logic [COUNT_BITS-1:0]   THIGH_END = COUNT_BITS'(TRIG_HIGH_TICKS);

  eur_phase_e              phase, phase_next;
  logic [COUNT_BITS-1:0]   phase_count, phase_count_next;
  logic [HOLDOFF_BITS-1:0] since_trigger, since_trigger_next;
  eur_flags_t              flags;
  logic [COUNT_BITS-1:0]   width;
  logic [COUNT_BITS-1:0]   eff_timeout;
  logic [COUNT_BITS-1:0]   count_inc;

  always_comb begin
    if (TCMP_BITS'(cfg.echo_timeout) < TCMP_BITS'(COUNT_MAX)) begin
      eff_timeout = COUNT_BITS'(cfg.echo_timeout);
    end else begin
      eff_timeout = COUNT_MAX;
    end
  end

  always_comb begin
    phase_next         = phase;
    phase_count_next   = phase_count;
    since_trigger_next = since_trigger;
    flags.trig         = 1'b0;
    flags.done         = 1'b0;
    flags.measured     = 1'b0;
    flags.status       = ST_OK;
    width              = '0;
    count_inc          = '0;

    if (since_trigger != HOLD_MAX) begin
      since_trigger_next = since_trigger + 1'b1;
    end

    if (phase_next == PH_IDLE && in_data.start_request) begin
      phase_next = PH_HOLD;
    end

    if (phase_next == PH_HOLD &&
        (HCMP_BITS'(since_trigger_next) >= HCMP_BITS'(cfg.holdoff_us) ||
         since_trigger_next == HOLD_MAX)) begin
      since_trigger_next = '0;
      phase_next         = PH_TLOW;
      phase_count_next   = '0;
    end

    count_inc = phase_count_next + 1'b1;
    if (phase_next == PH_TLOW) begin
      phase_count_next = count_inc;
      if (count_inc >= TLOW_END) begin
        phase_next       = PH_THIGH;
        phase_count_next = '0;
      end
    end else if (phase_next == PH_THIGH) begin
      flags.trig       = 1'b1;
      phase_count_next = count_inc;
      if (count_inc >= THIGH_END) begin
        phase_next       = PH_WAIT;
        phase_count_next = '0;
      end
    end else if (phase_next == PH_WAIT) begin
      priority if (in_data.echo_level) begin
        phase_next       = PH_MEAS;
        phase_count_next = '0;
      end else if (phase_count_next >= eff_timeout) begin
        flags.done       = 1'b1;
        flags.status     = ST_NO_EDGE;
        phase_next       = PH_IDLE;
        phase_count_next = '0;
      end else begin
        phase_count_next = count_inc;
      end
    end

    // the rise tick falls through into the width count on the same tick
    if (phase_next == PH_MEAS) begin
      priority if (!in_data.echo_level) begin
        width            = phase_count_next;
        flags.measured   = 1'b1;
        flags.done       = 1'b1;
        phase_next       = PH_IDLE;
        phase_count_next = '0;
      end else if (phase_count_next >= eff_timeout) begin
        width            = phase_count_next;
        flags.status     = ST_STUCK;
        flags.done       = 1'b1;
        phase_next       = PH_IDLE;
        phase_count_next = '0;
      end else begin
        phase_count_next = phase_count_next + 1'b1;
      end
    end

    flags.busy = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      phase_count   <= '0;
      since_trigger <= HOLD_MAX;
    end else if (in_fire) begin
      phase         <= phase_next;
      phase_count   <= phase_count_next;
      since_trigger <= since_trigger_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_flags <= flags;
      res_width <= width;
    end
  end

endmodule

[rtl/eur_range.sv]
// distance multiply and range check for a finished measurement
module eur_range #(
  parameter int COUNT_BITS = eur_pkg::DEF_COUNT_BITS
) (
  input  eur_pkg::eur_flags_t     flags,
  input  logic [COUNT_BITS-1:0]   width,
  input  eur_pkg::eur_cfg_t       cfg,
  output eur_pkg::eur_out_t       res
);
  import eur_pkg::*;

  localparam int PROD_BITS = (COUNT_BITS + SPEED_REG_BITS > 32) ?
                             COUNT_BITS + SPEED_REG_BITS : 32;

  logic [PROD_BITS-1:0]  product;
  logic [RANGE_BITS-1:0] distance;

  assign product  = PROD_BITS'(width) * PROD_BITS'(cfg.speed_q16);
  // width times speed over two, Q16 to Q8
  assign distance = product[DIST_SHIFT +: RANGE_BITS];

  always_comb begin
    res.trigger_level = flags.trig;
    res.busy_res      = flags.busy;
    res.done_res      = flags.done;
    res.width_us      = WIDTH_OUT_BITS'(width);
    res.distance_q8   = '0;
    res.status        = flags.status;
    if (flags.measured) begin
      res.distance_q8 = distance;
      if (distance < cfg.min_range_q8 || distance > cfg.max_range_q8) begin
        res.status = ST_RANGE;
      end else begin
        res.status = ST_OK;
      end
    end
  end

endmodule

[rtl/ultrasonic_echo_ranger.sv]
// top level of the ultrasonic echo ranger: config port, pipeline and output register
//
// Each input transaction is one microsecond tick carrying start_request and
// the sampled echo_level; each one gives exactly one output transaction with
// the trigger_level to drive, busy_res, and on the finishing tick done_res
// with status, width_us and distance_q8.
// Input and output use valid/stall; configuration is a plain write port
// (cfg_we, cfg_index, cfg_data) and should be written only while idle.
// Throughput is one tick per cycle while the receiver does not stall: the
// sequencer updates its state and a result register in the cycle of
// acceptance, and the distance multiply and range compare fill the output
// register from it; a tick passes through two register stages, the result
// register and the output register, before out_valid.
// When the receiver stalls, the output register holds its transaction and one
// more tick is taken into the result register; in_stall rises only when both
// are full and the output is stalled.
// Reset clears the pipeline, puts the sequencer in idle with the holdoff
// counter saturated (the first start triggers at once) and loads the
// register defaults.
module ultrasonic_echo_ranger #(
  parameter int COUNT_BITS   = eur_pkg::DEF_COUNT_BITS,
  parameter int HOLDOFF_BITS = eur_pkg::DEF_HOLDOFF_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  eur_pkg::eur_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output eur_pkg::eur_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [eur_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [eur_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import eur_pkg::*;

  eur_cfg_t              cfg;
  eur_flags_t            r1_flags;
  logic [COUNT_BITS-1:0] r1_width;
  logic                  r1_valid;
  eur_out_t              res;
  logic                  move_out;
  logic                  r1_fwd;
  logic                  in_fire;

  assign move_out = !out_valid || !out_stall;
  assign r1_fwd   = r1_valid && move_out;
  assign in_stall = r1_valid && !move_out;
  assign in_fire  = in_valid && !in_stall;

  eur_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  eur_step #(
    .COUNT_BITS   (COUNT_BITS),
    .HOLDOFF_BITS (HOLDOFF_BITS)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .cfg       (cfg),
    .res_flags (r1_flags),
    .res_width (r1_width)
  );

  eur_range #(
    .COUNT_BITS (COUNT_BITS)
  ) u_range (
    .flags (r1_flags),
    .width (r1_width),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        r1_valid <= 1'b1;
      end else if (r1_fwd) begin
        r1_valid <= 1'b0;
      end
      if (move_out) begin
        out_valid <= r1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1_fwd) begin
      out_data <= res;
    end
  end

  // a finished measurement always leaves the sequencer idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done transaction reports busy");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.done_res |->
      out_data.status == ST_OK && out_data.width_us == '0 &&
      out_data.distance_q8 == '0)
    else $error("result fields set without done");

  a_trig_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.trigger_level |-> out_data.busy_res)
    else $error("trigger driven while not busy");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> r1_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  a_fwd_lands: assert property (@(posedge clk) disable iff (rst)
    r1_fwd |=> out_valid)
    else $error("forwarded transaction lost");

endmodule

[bench/ultrasonic_echo_ranger_test.sv]
// self-checking testbench for the ultrasonic echo ranger, with its own tick-level ranging predictor
module ultrasonic_echo_ranger_test;
  import eur_pkg::*;

  localparam int unsigned IDLE_PCT       = 17;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned COUNT_LIMIT    = (1 << DEF_COUNT_BITS) - 1;
  localparam int unsigned HOLD_LIMIT     = (1 << DEF_HOLDOFF_BITS) - 1;
  localparam int unsigned RANGE_LIMIT    = (1 << RANGE_BITS) - 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  eur_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  eur_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  ultrasonic_echo_ranger DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  eur_in_t pending_ticks[$];
  eur_out_t expected_readings[$];
  int unsigned ticks_made = 0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  logic tick_taken = 1'b0;
  bit quiet_phase = 1'b0;

  // predictor state
  eur_cfg_t cfg_model;
  eur_phase_e seq_phase;
  int unsigned phase_ticks;
  int unsigned since_trig;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic eur_out_t ranger_tick(eur_in_t tick);
    eur_out_t r;
    int unsigned tmo;
    longint unsigned product;
    r = '0;
    tmo = (cfg_model.echo_timeout < COUNT_LIMIT) ? cfg_model.echo_timeout : COUNT_LIMIT;
    if (since_trig < HOLD_LIMIT) since_trig++;
    if (seq_phase == PH_IDLE && tick.start_request) seq_phase = PH_HOLD;
    if (seq_phase == PH_HOLD &&
        (since_trig >= cfg_model.holdoff_us || since_trig == HOLD_LIMIT)) begin
      since_trig = 0;
      seq_phase = PH_TLOW;
      phase_ticks = 0;
    end
    unique case (seq_phase)
      PH_TLOW: begin
        phase_ticks++;
        if (phase_ticks >= TRIG_LOW_TICKS) begin
          seq_phase = PH_THIGH;
          phase_ticks = 0;
        end
      end
      PH_THIGH: begin
        r.trigger_level = 1'b1;
        phase_ticks++;
        if (phase_ticks >= TRIG_HIGH_TICKS) begin
          seq_phase = PH_WAIT;
          phase_ticks = 0;
        end
      end
      PH_WAIT: begin
        if (tick.echo_level) begin
          seq_phase = PH_MEAS;
          phase_ticks = 0;
        end else if (phase_ticks >= tmo) begin
          r.done_res = 1'b1;
          r.status = ST_NO_EDGE;
          seq_phase = PH_IDLE;
          phase_ticks = 0;
        end else begin
          phase_ticks++;
        end
      end
      default: ;
    endcase
    // a rise seen this tick is already part of the width count
    if (seq_phase == PH_MEAS) begin
      if (!tick.echo_level) begin
        r.width_us = phase_ticks[WIDTH_OUT_BITS-1:0];
        product = longint'(phase_ticks) * cfg_model.speed_q16;
        r.distance_q8 = product[DIST_SHIFT +: RANGE_BITS];
        if (r.distance_q8 < cfg_model.min_range_q8 || r.distance_q8 > cfg_model.max_range_q8)
          r.status = ST_RANGE;
        else
          r.status = ST_OK;
        r.done_res = 1'b1;
        seq_phase = PH_IDLE;
        phase_ticks = 0;
      end else if (phase_ticks >= tmo) begin
        r.width_us = phase_ticks[WIDTH_OUT_BITS-1:0];
        r.status = ST_STUCK;
        r.done_res = 1'b1;
        seq_phase = PH_IDLE;
        phase_ticks = 0;
      end else begin
        phase_ticks++;
      end
    end
    r.busy_res = (seq_phase != PH_IDLE);
    return r;
  endfunction

  function automatic void check_field(string field, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    end
  endfunction

  // accept side: predict on every accepted tick
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      expected_readings.push_back(ranger_tick(in_data));
      tick_taken <= 1'b1;
    end else begin
      tick_taken <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || tick_taken) begin
      if (pending_ticks.size() != 0 && (quiet_phase || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_data <= pending_ticks.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !quiet_phase && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    eur_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        error_count++;
        $display("%0t: unexpected transaction, expected none actual %h", $time, out_data);
      end else begin
        want = expected_readings.pop_front();
        check_field("trigger_level", want.trigger_level, out_data.trigger_level);
        check_field("busy_res", want.busy_res, out_data.busy_res);
        check_field("done_res", want.done_res, out_data.done_res);
        check_field("status", want.status, out_data.status);
        check_field("width_us", want.width_us, out_data.width_us);
        check_field("distance_q8", want.distance_q8, out_data.distance_q8);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("ultrasonic_echo_ranger_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    unique case (idx)
      CFG_HOLDOFF: cfg_model.holdoff_us = value[HOLDOFF_REG_BITS-1:0];
      CFG_TIMEOUT: cfg_model.echo_timeout = value[TIMEOUT_REG_BITS-1:0];
      CFG_SPEED:   cfg_model.speed_q16 = value[SPEED_REG_BITS-1:0];
      CFG_MIN:     cfg_model.min_range_q8 = value[RANGE_BITS-1:0];
      CFG_MAX:     cfg_model.max_range_q8 = value[RANGE_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_cfg(int unsigned hold, int unsigned tmo, int unsigned spd,
                         int unsigned lo, int unsigned hi);
    write_reg(CFG_HOLDOFF, CFG_DATA_BITS'(hold));
    write_reg(CFG_TIMEOUT, CFG_DATA_BITS'(tmo));
    write_reg(CFG_SPEED, CFG_DATA_BITS'(spd));
    write_reg(CFG_MIN, CFG_DATA_BITS'(lo));
    write_reg(CFG_MAX, CFG_DATA_BITS'(hi));
  endtask

  // wait until every queued tick is taken and every reading has come back
  task automatic drain();
    do @(posedge clk);
    while (pending_ticks.size() != 0 || in_valid || expected_readings.size() != 0);
  endtask

  task automatic add_tick(bit start, bit echo);
    eur_in_t t;
    t.start_request = start;
    t.echo_level = echo;
    pending_ticks.push_back(t);
    ticks_made++;
  endtask

  // one well-formed ping: start, trigger ticks, quiet echo, echo pulse, echo low
  task automatic add_ping(int unsigned rise_delay, int unsigned high_ticks, bit start_at_end);
    add_tick(1'b1, 1'($urandom_range(1)));
    repeat (TRIG_LOW_TICKS + TRIG_HIGH_TICKS - 1)
      add_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
    repeat (rise_delay) add_tick($urandom_range(9) == 0, 1'b0);
    repeat (high_ticks) add_tick($urandom_range(9) == 0, 1'b1);
    add_tick(start_at_end, 1'b0);
  endtask

  task automatic random_pings(int unsigned n_ticks, int unsigned tmo);
    int unsigned goal;
    goal = ticks_made + n_ticks;
    while (ticks_made < goal) begin
      if ($urandom_range(99) < 80) begin
        add_ping(($urandom_range(3) == 0) ? tmo + $urandom_range(2, 1) : $urandom_range(tmo),
                 ($urandom_range(3) == 0) ? tmo + $urandom_range(2, 1)
                                          : $urandom_range(tmo, 1),
                 1'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(8, 1)) add_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      repeat ($urandom_range(2)) add_tick(1'b0, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    int unsigned hold, tmo, spd, lo, hi, span;
    cfg_model = '{HOLDOFF_RESET, TIMEOUT_RESET, SPEED_RESET, MIN_RESET, MAX_RESET};
    seq_phase = PH_IDLE;
    phase_ticks = 0;
    since_trig = HOLD_LIMIT;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // saturated holdoff counter lets the first start through even at the largest holdoff
    write_reg(CFG_HOLDOFF, CFG_DATA_BITS'(HOLD_LIMIT));
    write_reg(CFG_TIMEOUT, '0);
    write_reg(CFG_SPARE, '1);
    add_ping(0, 0, 1'b1);
    add_tick(1'b0, 1'b0);
    // second start is held back by the holdoff
    add_ping(0, 1, 1'b0);
    drain();
    write_reg(CFG_HOLDOFF, '0);
    repeat (TRIG_LOW_TICKS + TRIG_HIGH_TICKS) add_tick(1'b0, 1'($urandom_range(1)));
    add_tick(1'b0, 1'b1);
    add_tick(1'b0, 1'b0);
    drain();

    // range edges: distance equals width at this speed
    set_cfg(0, 10, 512, 3, 5);
    add_ping(1, 2, 1'b0);
    add_ping(0, 3, 1'b0);
    add_ping(2, 5, 1'b1);
    add_ping(0, 6, 1'b0);
    add_ping(11, 0, 1'b0);
    add_ping(0, 11, 1'b0);
    drain();
    set_cfg(0, 10, 1, 0, 5);
    add_ping(3, 4, 1'b0);
    drain();
    set_cfg(0, 10, COUNT_LIMIT, RANGE_LIMIT, 0);
    add_ping(0, 5, 1'b0);
    drain();

    // largest timeout and speed
    set_cfg(0, COUNT_LIMIT, COUNT_LIMIT, 0, RANGE_LIMIT);
    add_ping(3, 20, 1'b0);
    drain();

    for (int p = 0; p < 5; p++) begin
      hold = $urandom_range(14);
      tmo = $urandom_range(16, 4);
      spd = $urandom_range(COUNT_LIMIT, 1);
      span = (tmo * spd) >> DIST_SHIFT;
      lo = $urandom_range(span / 2);
      hi = $urandom_range(span + 1, lo);
      unique case (p)
        1: quiet_phase = 1'b1;
        2: begin
          hold = 0;
          spd = COUNT_LIMIT;
          lo = 0;
          hi = RANGE_LIMIT;
        end
        3: begin
          tmo = 1;
          spd = 1;
          lo = $urandom_range(RANGE_LIMIT, 1);
          hi = $urandom_range(lo - 1);
        end
        4: hold = $urandom_range(60, 30);
        default: ;
      endcase
      set_cfg(hold, tmo, spd, lo, hi);
      random_pings(30, tmo);
      drain();
      quiet_phase = 1'b0;
    end

    repeat (10) @(posedge clk);
    if (expected_readings.size() != 0) begin
      error_count++;
      $display("%0t: readings left over, expected 0 actual %0d", $time,
               expected_readings.size());
    end
    if (error_count == 0) begin
      $display("ultrasonic_echo_ranger_test: done, clean");
    end else begin
      $display("ultrasonic_echo_ranger_test: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/eur_pkg.sv
rtl/eur_cfg_regs.sv
rtl/eur_step.sv
rtl/eur_range.sv
rtl/ultrasonic_echo_ranger.sv
bench/ultrasonic_echo_ranger_test.sv
